[rtl/core/ffca_pkg.sv]
// Shared constants for the first-fit contiguous slot allocator.
package ffca_pkg;

  localparam int unsigned FIELD_W       = 11;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned WORD_W        = 16;
  localparam int unsigned BIT_W         = 4;
  localparam int unsigned DEF_MAX_SLOTS = 1024;
  localparam int unsigned DEF_SEATS     = 1024;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

[rtl/core/ffca_range_mask.sv]
// Bit mask of the slots of one bitmap word that fall inside a slot range.
module ffca_range_mask #(
  parameter int unsigned SW = 11,
  parameter int unsigned AW = 6
) (
  input  logic [AW-1:0]              word_i,
  input  logic [SW-1:0]              first_i,
  input  logic [SW-1:0]              last_i,
  output logic [ffca_pkg::WORD_W-1:0] mask_o
);
  import ffca_pkg::*;

  logic [31:0] base;
  logic [31:0] slot [WORD_W];

  always_comb begin
    base = 32'(word_i) << BIT_W;
    for (int i = 0; i < int'(WORD_W); i++) begin
      slot[i]   = base + 32'(i) + 32'd1;
      mask_o[i] = (slot[i] >= 32'(first_i)) && (slot[i] <= 32'(last_i));
    end
  end

endmodule

[rtl/core/first_fit_contiguous_slot_allocator.sv]
// Top level of the first-fit contiguous slot allocator.
// A request is taken when start_i is high, busy_o is low and seat_count_we_i
// is low. cmd_i selects allocate (find the leftmost run of run_length_i free
// slots and take it) or free (release range_first_i to range_last_i, clipped
// to the slot row). Each request gives one result: done_o is high for exactly
// one cycle with granted_o, start_slot_o and reject_total_o valid; the receiver
// cannot stall. Slot state lives in a bitmap memory of 16-bit words with one
// read and one write port. An allocate scans one slot per cycle, pausing at
// each word for the registered read in S_SCAN_RD, then reads and writes back
// each word that the run covers (S_FILL_RD, S_FILL_WR).
// A free reads and writes back each word of the clipped range in the same way.
// A zero run length or an empty free range finishes straight from idle.
// Reset and every write of seat_count_i taken while idle start a clearing pass
// over all ceil(MAX_SLOTS / 16) words that marks all slots free; busy_o is high
// meanwhile. seat_count_i of zero is taken as one, above MAX_SLOTS as
// MAX_SLOTS. Refused allocates increment a saturating 32-bit reject count.
module first_fit_contiguous_slot_allocator #(
  parameter int unsigned MAX_SLOTS = ffca_pkg::DEF_MAX_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cmd_i,
  input  logic [ffca_pkg::FIELD_W-1:0]  run_length_i,
  input  logic [ffca_pkg::FIELD_W-1:0]  range_first_i,
  input  logic [ffca_pkg::FIELD_W-1:0]  range_last_i,
  input  logic                          seat_count_we_i,
  input  logic [ffca_pkg::FIELD_W-1:0]  seat_count_i,
  output logic                          done_o,
  output logic                          granted_o,
  output logic [ffca_pkg::FIELD_W-1:0]  start_slot_o,
  output logic [ffca_pkg::CNT_W-1:0]    reject_total_o
);
  import ffca_pkg::*;

  localparam int unsigned SW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW = SW + 1;
  localparam int unsigned NW = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_SCAN_RD  = 6'b000100,
    S_SCAN_BIT = 6'b001000,
    S_FILL_RD  = 6'b010000,
    S_FILL_WR  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [SW-1:0]       seat_q, seat_d;
  logic [CW-1:0]       s_q, s_d;
  logic [CW-1:0]       run_q, run_d;
  logic [SW-1:0]       cand_q, cand_d;
  logic [SW-1:0]       a_q, a_d;
  logic [SW-1:0]       b_q, b_d;
  logic [AW-1:0]       w_q, w_d;
  logic [AW-1:0]       wb_q, wb_d;
  logic                cmd_q, cmd_d;
  logic [FIELD_W-1:0]  len_q, len_d;
  logic                done_q, done_d;
  logic                granted_q, granted_d;
  logic [SW-1:0]       start_q, start_d;
  logic [CNT_W-1:0]    reject_q, reject_d;

  logic [WORD_W-1:0]   mem [NW];
  logic [WORD_W-1:0]   rdata_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic [WORD_W-1:0]   mask;

  logic [SW-1:0]       scan_idx;
  logic [BIT_W-1:0]    scan_bit;
  logic [31:0]         free_a, free_b, seat_clip;
  logic [SW-1:0]       cand_cur;
  logic [SW-1:0]       idx_a, idx_b;

  ffca_range_mask #(
    .SW (SW),
    .AW (AW)
  ) u_mask (
    .word_i  (w_q),
    .first_i (a_q),
    .last_i  (b_q),
    .mask_o  (mask)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    scan_idx = SW'(s_q - CW'(1));
    scan_bit = BIT_W'(scan_idx);
    cand_cur = (run_q == '0) ? SW'(s_q) : cand_q;

    seat_clip = 32'(seat_count_i);
    if (seat_clip == 32'd0) begin
      seat_clip = 32'd1;
    end
    if (seat_clip > 32'(MAX_SLOTS)) begin
      seat_clip = 32'(MAX_SLOTS);
    end

    free_a = (range_first_i == '0) ? 32'd1 : 32'(range_first_i);
    free_b = (32'(range_last_i) > 32'(seat_q)) ? 32'(seat_q) : 32'(range_last_i);
    idx_a  = SW'(free_a - 32'd1);
    idx_b  = SW'(free_b - 32'd1);

    state_d   = state_q;
    seat_d    = seat_q;
    s_d       = s_q;
    run_d     = run_q;
    cand_d    = cand_q;
    a_d       = a_q;
    b_d       = b_q;
    w_d       = w_q;
    wb_d      = wb_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    start_d   = start_q;
    reject_d  = reject_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = w_q;
    mem_raddr = w_q;
    mem_wdata = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        w_d    = w_q + AW'(1);
        if (w_q == LAST_WORD) begin
          w_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (seat_count_we_i) begin
          seat_d  = SW'(seat_clip);
          w_d     = '0;
          state_d = S_CLEAR;
        end else if (start_i) begin
          cmd_d = cmd_i;
          len_d = run_length_i;
          if (cmd_i == CMD_ALLOC) begin
            if (run_length_i == '0) begin
              done_d    = 1'b1;
              granted_d = 1'b1;
              start_d   = SW'(1);
            end else begin
              s_d     = CW'(1);
              run_d   = '0;
              state_d = S_SCAN_RD;
            end
          end else begin
            granted_d = 1'b1;
            start_d   = '0;
            if (free_a > free_b) begin
              done_d = 1'b1;
            end else begin
              a_d     = SW'(free_a);
              b_d     = SW'(free_b);
              w_d     = AW'(idx_a >> BIT_W);
              wb_d    = AW'(idx_b >> BIT_W);
              state_d = S_FILL_RD;
            end
          end
        end
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(scan_idx >> BIT_W);
        state_d   = S_SCAN_BIT;
      end
      S_SCAN_BIT: begin
        if (32'(s_q) > 32'(seat_q)) begin
          done_d    = 1'b1;
          granted_d = 1'b0;
          start_d   = '0;
          if (reject_q != '1) begin
            reject_d = reject_q + CNT_W'(1);
          end
          state_d = S_IDLE;
        end else if (!rdata_q[scan_bit]) begin
          cand_d = cand_cur;
          run_d  = run_q + CW'(1);
          if (32'(run_q) + 32'd1 == 32'(len_q)) begin
            granted_d = 1'b1;
            start_d   = cand_cur;
            a_d       = cand_cur;
            b_d       = SW'(s_q);
            w_d       = AW'(SW'(cand_cur - SW'(1)) >> BIT_W);
            wb_d      = AW'(scan_idx >> BIT_W);
            state_d   = S_FILL_RD;
          end else begin
            s_d = s_q + CW'(1);
            if (scan_bit == '1) begin
              state_d = S_SCAN_RD;
            end
          end
        end else begin
          run_d = '0;
          s_d   = s_q + CW'(1);
          if (scan_bit == '1) begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_FILL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = w_q;
        state_d   = S_FILL_WR;
      end
      S_FILL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = w_q;
        mem_wdata = (cmd_q == CMD_FREE) ? (rdata_q & ~mask) : (rdata_q | mask);
        if (w_q == wb_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          w_d     = w_q + AW'(1);
          state_d = S_FILL_RD;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      seat_q    <= SW'(DEF_SEATS > MAX_SLOTS ? MAX_SLOTS : DEF_SEATS);
      w_q       <= '0;
      done_q    <= 1'b0;
      granted_q <= 1'b0;
      start_q   <= '0;
      reject_q  <= '0;
    end else begin
      state_q   <= state_d;
      seat_q    <= seat_d;
      w_q       <= w_d;
      done_q    <= done_d;
      granted_q <= granted_d;
      start_q   <= start_d;
      reject_q  <= reject_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    run_q  <= run_d;
    cand_q <= cand_d;
    a_q    <= a_d;
    b_q    <= b_d;
    wb_q   <= wb_d;
    cmd_q  <= cmd_d;
    len_q  <= len_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign granted_o      = granted_q;
  assign start_slot_o   = FIELD_W'(start_q);
  assign reject_total_o = reject_q;

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q != S_CLEAR))
    else $error("Result issued during the clearing pass.");

  a_refusal_has_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !granted_q) |-> (start_q == '0) && (reject_q != '0))
    else $error("Refused request carries a slot or an empty reject count.");

  a_grant_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && granted_q && start_q != '0) |-> (start_q <= seat_q))
    else $error("Granted slot lies beyond the slot row.");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !seat_count_we_i && !done_d) |=> busy_o)
    else $error("Long request did not raise busy.");

  a_reject_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(reject_q) |-> (done_q && !granted_q))
    else $error("Reject count changed without a refusal.");

endmodule
